// ===== src/iglfp_pkg.sv =====
// Shared types, codes and defaults for the GCD / LCM / factorial / power unit.
package iglfp_pkg;

   localparam int unsigned OPERAND_WIDTH_DEF = 16;
   localparam int unsigned RESULT_WIDTH_DEF  = 64;

   typedef enum logic [1:0] {
      OP_LCM  = 2'd0,
      OP_GCD  = 2'd1,
      OP_FACT = 2'd2,
      OP_POW  = 2'd3
   } opcode_type;

   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_OVF = 2'd1;
   localparam logic [1:0] ST_BAD = 2'd2;

   localparam logic [1:0] COUNT_TWO   = 2'd2;
   localparam logic [1:0] COUNT_THREE = 2'd3;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_DIV_GCD,
      CMD_DIV_Q1,
      CMD_DIV_Q2,
      CMD_DIV_STEP,
      CMD_GCD_NEXT,
      CMD_GCD_C,
      CMD_MUL_QB,
      CMD_MUL_QC,
      CMD_MUL_ACCK,
      CMD_MUL_AB,
      CMD_MUL_BB,
      CMD_MUL_STEP,
      CMD_TAKE_L,
      CMD_FACT_INIT,
      CMD_ACC_TAKE,
      CMD_POW_INIT,
      CMD_ACC_POW_TAKE,
      CMD_BASE_TAKE,
      CMD_FIN_PROD,
      CMD_FIN_GCD,
      CMD_FIN_ACC,
      CMD_FIN_BAD,
      CMD_OUT
   } cmd_type;

   typedef struct packed {
      opcode_type opcode;
      logic       three;
      logic       bad;
      logic       v_zero;
      logic       div_done;
      logic       mul_done;
      logic       fact_done;
      logic       e_zero;
      logic       e_odd;
   } dp_status_type;

endpackage

// ===== src/iglfp_if.sv =====
// Request and response channel interfaces of the GCD / LCM / factorial / power unit.
interface iglfp_req_if #(
   parameter int unsigned OPERAND_WIDTH = iglfp_pkg::OPERAND_WIDTH_DEF
);
   logic                     valid;
   logic                     ready;
   logic [1:0]               opcode;
   logic [1:0]               operand_count;
   logic [OPERAND_WIDTH-1:0] operand_a;
   logic [OPERAND_WIDTH-1:0] operand_b;
   logic [OPERAND_WIDTH-1:0] operand_c;

   modport source (output valid, opcode, operand_count, operand_a, operand_b, operand_c,
                   input ready);
   modport sink (input valid, opcode, operand_count, operand_a, operand_b, operand_c,
                 output ready);
endinterface

interface iglfp_rsp_if #(
   parameter int unsigned RESULT_WIDTH = iglfp_pkg::RESULT_WIDTH_DEF
);
   logic                    valid;
   logic                    ready;
   logic [RESULT_WIDTH-1:0] result_value;
   logic [1:0]              status;

   modport source (output valid, result_value, status, input ready);
   modport sink (input valid, result_value, status, output ready);
endinterface

// ===== src/iglfp_datapath.sv =====
// Datapath: operand registers, serial divider, shift-add multiplier and result registers.
module iglfp_datapath #(
   parameter int unsigned OPERAND_WIDTH = iglfp_pkg::OPERAND_WIDTH_DEF,
   parameter int unsigned RESULT_WIDTH  = iglfp_pkg::RESULT_WIDTH_DEF
) (
   input  logic                        clock,
   input  iglfp_pkg::cmd_type          cmd,
   input  logic [1:0]                  req_opcode,
   input  logic [1:0]                  req_operand_count,
   input  logic [OPERAND_WIDTH-1:0]    req_operand_a,
   input  logic [OPERAND_WIDTH-1:0]    req_operand_b,
   input  logic [OPERAND_WIDTH-1:0]    req_operand_c,
   output iglfp_pkg::dp_status_type    sts,
   output logic [RESULT_WIDTH-1:0]     rsp_result_value,
   output logic [1:0]                  rsp_status
);

   localparam int unsigned OW = OPERAND_WIDTH;
   localparam int unsigned RW = RESULT_WIDTH;
   localparam int unsigned MW = (2 * OW > RW) ? 2 * OW : RW;
   localparam int unsigned PW = 2 * MW;
   localparam int unsigned KW = OW + 1;
   localparam int unsigned CW = $clog2(MW + 1);

   iglfp_pkg::opcode_type opc_ff;
   logic                  three_ff;
   logic                  bad_ff;
   logic [OW-1:0]         a_ff, b_ff, c_ff;
   logic [MW-1:0]         u_ff, v_ff, w_ff;
   logic [MW-1:0]         dn_ff, dd_ff, drem_ff;
   logic [CW-1:0]         dcnt_ff;
   logic [PW-1:0]         mx_ff, mp_ff;
   logic [MW-1:0]         my_ff;
   logic [RW-1:0]         acc_ff, base_ff, res_ff;
   logic                  base_big_ff, ovf_ff;
   logic [KW-1:0]         k_ff;
   logic [OW-1:0]         e_ff;
   logic [1:0]            st_ff;
   logic [RW-1:0]         out_value_ff;
   logic [1:0]            out_status_ff;

   logic                  cnt_ok, in_three, in_bad;
   logic                  a_zero, b_zero, c_zero;
   logic [MW:0]           trial, diff;
   logic                  trial_ge;
   logic                  prod_hi;
   logic [MW-1:0]         a_ext;

   // Validity of a request, judged on the incoming word
   always_comb begin
      cnt_ok   = (req_operand_count == iglfp_pkg::COUNT_TWO) ||
                 (req_operand_count == iglfp_pkg::COUNT_THREE);
      in_three = (req_operand_count == iglfp_pkg::COUNT_THREE);
      a_zero   = (req_operand_a == '0);
      b_zero   = (req_operand_b == '0);
      c_zero   = (req_operand_c == '0);
      unique case (iglfp_pkg::opcode_type'(req_opcode))
         iglfp_pkg::OP_LCM: in_bad = !cnt_ok || a_zero || b_zero || (in_three && c_zero);
         iglfp_pkg::OP_GCD: in_bad = !cnt_ok || (a_zero && b_zero && (!in_three || c_zero));
         default:           in_bad = 1'b0;
      endcase
   end

   assign trial    = {drem_ff, dn_ff[MW-1]};
   assign trial_ge = (trial >= {1'b0, dd_ff});
   assign diff     = trial - {1'b0, dd_ff};
   assign prod_hi  = (mp_ff[PW-1:RW] != '0);
   assign a_ext    = MW'(a_ff);

   always_ff @(posedge clock) begin
      unique case (cmd)
         iglfp_pkg::CMD_NONE: begin
         end
         iglfp_pkg::CMD_LOAD: begin
            opc_ff   <= iglfp_pkg::opcode_type'(req_opcode);
            three_ff <= in_three;
            bad_ff   <= in_bad;
            a_ff     <= req_operand_a;
            b_ff     <= req_operand_b;
            c_ff     <= req_operand_c;
            u_ff     <= MW'(req_operand_a);
            v_ff     <= MW'(req_operand_b);
         end
         iglfp_pkg::CMD_DIV_GCD: begin
            dn_ff   <= u_ff;
            dd_ff   <= v_ff;
            drem_ff <= '0;
            dcnt_ff <= CW'(MW);
         end
         iglfp_pkg::CMD_DIV_Q1: begin
            dn_ff   <= a_ext;
            dd_ff   <= u_ff;
            drem_ff <= '0;
            dcnt_ff <= CW'(MW);
         end
         iglfp_pkg::CMD_DIV_Q2: begin
            dn_ff   <= w_ff;
            dd_ff   <= u_ff;
            drem_ff <= '0;
            dcnt_ff <= CW'(MW);
         end
         iglfp_pkg::CMD_DIV_STEP: begin
            drem_ff <= trial_ge ? diff[MW-1:0] : trial[MW-1:0];
            dn_ff   <= {dn_ff[MW-2:0], trial_ge};
            dcnt_ff <= dcnt_ff - CW'(1);
         end
         iglfp_pkg::CMD_GCD_NEXT: begin
            u_ff <= v_ff;
            v_ff <= drem_ff;
         end
         iglfp_pkg::CMD_GCD_C: begin
            v_ff <= MW'(c_ff);
         end
         iglfp_pkg::CMD_MUL_QB: begin
            mx_ff <= PW'(dn_ff);
            my_ff <= MW'(b_ff);
            mp_ff <= '0;
         end
         iglfp_pkg::CMD_MUL_QC: begin
            mx_ff <= PW'(dn_ff);
            my_ff <= MW'(c_ff);
            mp_ff <= '0;
         end
         iglfp_pkg::CMD_MUL_ACCK: begin
            mx_ff <= PW'(acc_ff);
            my_ff <= MW'(k_ff);
            mp_ff <= '0;
         end
         iglfp_pkg::CMD_MUL_AB: begin
            mx_ff <= PW'(acc_ff);
            my_ff <= MW'(base_ff);
            mp_ff <= '0;
         end
         iglfp_pkg::CMD_MUL_BB: begin
            mx_ff <= PW'(base_ff);
            my_ff <= MW'(base_ff);
            mp_ff <= '0;
         end
         iglfp_pkg::CMD_MUL_STEP: begin
            if (my_ff[0]) begin
               mp_ff <= mp_ff + mx_ff;
            end
            mx_ff <= {mx_ff[PW-2:0], 1'b0};
            my_ff <= {1'b0, my_ff[MW-1:1]};
         end
         iglfp_pkg::CMD_TAKE_L: begin
            w_ff <= mp_ff[MW-1:0];
            u_ff <= mp_ff[MW-1:0];
            v_ff <= MW'(c_ff);
         end
         iglfp_pkg::CMD_FACT_INIT: begin
            acc_ff <= RW'(1);
            k_ff   <= KW'(2);
            ovf_ff <= 1'b0;
         end
         iglfp_pkg::CMD_ACC_TAKE: begin
            acc_ff <= mp_ff[RW-1:0];
            ovf_ff <= ovf_ff | prod_hi;
            k_ff   <= k_ff + KW'(1);
         end
         iglfp_pkg::CMD_POW_INIT: begin
            acc_ff      <= RW'(1);
            base_ff     <= a_ext[RW-1:0];
            base_big_ff <= ((a_ext >> RW) != '0);
            e_ff        <= b_ff;
            ovf_ff      <= 1'b0;
         end
         iglfp_pkg::CMD_ACC_POW_TAKE: begin
            acc_ff <= mp_ff[RW-1:0];
            ovf_ff <= ovf_ff | base_big_ff | prod_hi;
         end
         iglfp_pkg::CMD_BASE_TAKE: begin
            base_ff     <= mp_ff[RW-1:0];
            base_big_ff <= base_big_ff | prod_hi;
            e_ff        <= {1'b0, e_ff[OW-1:1]};
         end
         iglfp_pkg::CMD_FIN_PROD: begin
            res_ff <= mp_ff[RW-1:0];
            st_ff  <= prod_hi ? iglfp_pkg::ST_OVF : iglfp_pkg::ST_OK;
         end
         iglfp_pkg::CMD_FIN_GCD: begin
            res_ff <= u_ff[RW-1:0];
            st_ff  <= ((u_ff >> RW) != '0) ? iglfp_pkg::ST_OVF : iglfp_pkg::ST_OK;
         end
         iglfp_pkg::CMD_FIN_ACC: begin
            res_ff <= acc_ff;
            st_ff  <= ovf_ff ? iglfp_pkg::ST_OVF : iglfp_pkg::ST_OK;
         end
         iglfp_pkg::CMD_FIN_BAD: begin
            res_ff <= '0;
            st_ff  <= iglfp_pkg::ST_BAD;
         end
         iglfp_pkg::CMD_OUT: begin
            out_value_ff  <= res_ff;
            out_status_ff <= st_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      sts.opcode    = opc_ff;
      sts.three     = three_ff;
      sts.bad       = bad_ff;
      sts.v_zero    = (v_ff == '0);
      sts.div_done  = (dcnt_ff == '0);
      sts.mul_done  = (my_ff == '0);
      sts.fact_done = ({1'b0, a_ff} < k_ff) || (acc_ff == '0);
      sts.e_zero    = (e_ff == '0);
      sts.e_odd     = e_ff[0];
   end

   assign rsp_result_value = out_value_ff;
   assign rsp_status       = out_status_ff;

endmodule

// ===== src/iglfp_ctrl.sv =====
// Controller: sequences the datapath through GCD, LCM, factorial and power algorithms.
module iglfp_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  iglfp_pkg::dp_status_type  sts,
   output iglfp_pkg::cmd_type        cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_GCD_TEST,
      S_DIV_RUN,
      S_MUL_RUN,
      S_FACT_TEST,
      S_POW_TEST,
      S_POW_SQ,
      S_OUT
   } state_type;

   typedef enum logic [2:0] {
      PH_GCD1,
      PH_GCD2,
      PH_Q1,
      PH_Q2,
      PH_FACT,
      PH_POWA,
      PH_POWB
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = iglfp_pkg::CMD_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd      = iglfp_pkg::CMD_LOAD;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.bad) begin
               cmd      = iglfp_pkg::CMD_FIN_BAD;
               state_in = S_OUT;
            end else begin
               unique case (sts.opcode)
                  iglfp_pkg::OP_LCM, iglfp_pkg::OP_GCD: begin
                     phase_in = PH_GCD1;
                     state_in = S_GCD_TEST;
                  end
                  iglfp_pkg::OP_FACT: begin
                     cmd      = iglfp_pkg::CMD_FACT_INIT;
                     state_in = S_FACT_TEST;
                  end
                  default: begin
                     cmd      = iglfp_pkg::CMD_POW_INIT;
                     state_in = S_POW_TEST;
                  end
               endcase
            end
         end
         S_GCD_TEST: begin
            if (!sts.v_zero) begin
               cmd      = iglfp_pkg::CMD_DIV_GCD;
               state_in = S_DIV_RUN;
            end else if (sts.opcode == iglfp_pkg::OP_GCD) begin
               if (phase_ff == PH_GCD1 && sts.three) begin
                  cmd      = iglfp_pkg::CMD_GCD_C;
                  phase_in = PH_GCD2;
               end else begin
                  cmd      = iglfp_pkg::CMD_FIN_GCD;
                  state_in = S_OUT;
               end
            end else if (phase_ff == PH_GCD1) begin
               cmd      = iglfp_pkg::CMD_DIV_Q1;
               phase_in = PH_Q1;
               state_in = S_DIV_RUN;
            end else begin
               cmd      = iglfp_pkg::CMD_DIV_Q2;
               phase_in = PH_Q2;
               state_in = S_DIV_RUN;
            end
         end
         S_DIV_RUN: begin
            if (!sts.div_done) begin
               cmd = iglfp_pkg::CMD_DIV_STEP;
            end else if (phase_ff == PH_Q1) begin
               cmd      = iglfp_pkg::CMD_MUL_QB;
               state_in = S_MUL_RUN;
            end else if (phase_ff == PH_Q2) begin
               cmd      = iglfp_pkg::CMD_MUL_QC;
               state_in = S_MUL_RUN;
            end else begin
               cmd      = iglfp_pkg::CMD_GCD_NEXT;
               state_in = S_GCD_TEST;
            end
         end
         S_MUL_RUN: begin
            if (!sts.mul_done) begin
               cmd = iglfp_pkg::CMD_MUL_STEP;
            end else begin
               unique case (phase_ff)
                  PH_Q1: begin
                     if (sts.three) begin
                        cmd      = iglfp_pkg::CMD_TAKE_L;
                        phase_in = PH_GCD2;
                        state_in = S_GCD_TEST;
                     end else begin
                        cmd      = iglfp_pkg::CMD_FIN_PROD;
                        state_in = S_OUT;
                     end
                  end
                  PH_FACT: begin
                     cmd      = iglfp_pkg::CMD_ACC_TAKE;
                     state_in = S_FACT_TEST;
                  end
                  PH_POWA: begin
                     cmd      = iglfp_pkg::CMD_ACC_POW_TAKE;
                     state_in = S_POW_SQ;
                  end
                  PH_POWB: begin
                     cmd      = iglfp_pkg::CMD_BASE_TAKE;
                     state_in = S_POW_TEST;
                  end
                  default: begin
                     cmd      = iglfp_pkg::CMD_FIN_PROD;
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_FACT_TEST: begin
            if (sts.fact_done) begin
               cmd      = iglfp_pkg::CMD_FIN_ACC;
               state_in = S_OUT;
            end else begin
               cmd      = iglfp_pkg::CMD_MUL_ACCK;
               phase_in = PH_FACT;
               state_in = S_MUL_RUN;
            end
         end
         S_POW_TEST: begin
            if (sts.e_zero) begin
               cmd      = iglfp_pkg::CMD_FIN_ACC;
               state_in = S_OUT;
            end else if (sts.e_odd) begin
               cmd      = iglfp_pkg::CMD_MUL_AB;
               phase_in = PH_POWA;
               state_in = S_MUL_RUN;
            end else begin
               cmd      = iglfp_pkg::CMD_MUL_BB;
               phase_in = PH_POWB;
               state_in = S_MUL_RUN;
            end
         end
         S_POW_SQ: begin
            cmd      = iglfp_pkg::CMD_MUL_BB;
            phase_in = PH_POWB;
            state_in = S_MUL_RUN;
         end
         S_OUT: begin
            if (out_free) begin
               cmd          = iglfp_pkg::CMD_OUT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_GCD1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Never overwrite a word still waiting on the response side
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      (cmd == iglfp_pkg::CMD_OUT) |-> out_free)
      else $error("response register overwritten while full");

   // An accepted request always starts with the validity check
   a_load_check: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_CHECK))
      else $error("accepted request not checked");

   // Divider steps only while bits remain
   a_div_bounded: assert property (@(posedge clock) disable iff (reset)
      (cmd == iglfp_pkg::CMD_DIV_STEP) |-> !sts.div_done)
      else $error("divider stepped past its last bit");

   // A completed response sets valid on the next edge
   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd == iglfp_pkg::CMD_OUT) |=> rsp_valid_ff)
      else $error("response not presented");

endmodule

// ===== src/integer_gcd_lcm_factorial_power_unit.sv =====
// Integer GCD / LCM / factorial / power unit: one request word in, one response word out.
// Each request selects LCM or GCD of two or three operands, the factorial of operand_a,
// or operand_a raised to operand_b; the response carries the value modulo
// 2^RESULT_WIDTH and a status (ok, overflow, or invalid with value 0). Requests are
// handled one at a time by a controller stepping a shared serial divider (one quotient
// bit per cycle) and a shift-add multiplier (one multiplier bit per cycle). The time a
// request takes therefore depends on the data: a divide runs over W quotient bits and
// a multiply over at most W multiplier bits, W being the larger of 2*OPERAND_WIDTH and
// RESULT_WIDTH. A GCD or LCM is quickest with a zero operand, a power takes about
// 2*log2(exponent) multiplies, and a factorial n-1 multiplies, stopping early once the
// wrapped product reaches zero (65 multiplies at a 64-bit result). A finished
// response sits in an output register, so the next request is accepted while it waits.
module integer_gcd_lcm_factorial_power_unit #(
   parameter int unsigned OPERAND_WIDTH = iglfp_pkg::OPERAND_WIDTH_DEF,
   parameter int unsigned RESULT_WIDTH  = iglfp_pkg::RESULT_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   iglfp_req_if.sink  req_ch,
   iglfp_rsp_if.source rsp_ch
);

   iglfp_pkg::cmd_type       cmd;
   iglfp_pkg::dp_status_type sts;

   // Sequence the algorithms; own the handshakes
   iglfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Hold operands, run divide and multiply, and register the response word
   iglfp_datapath #(
      .OPERAND_WIDTH (OPERAND_WIDTH),
      .RESULT_WIDTH  (RESULT_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .cmd               (cmd),
      .req_opcode        (req_ch.opcode),
      .req_operand_count (req_ch.operand_count),
      .req_operand_a     (req_ch.operand_a),
      .req_operand_b     (req_ch.operand_b),
      .req_operand_c     (req_ch.operand_c),
      .sts               (sts),
      .rsp_result_value  (rsp_ch.result_value),
      .rsp_status        (rsp_ch.status)
   );

endmodule
